// File: rtl/eltu_pkg.sv
`default_nettype none
package eltu_pkg;

  localparam int NODES      = 64;
  localparam int SEL_COLS   = 32;
  localparam int GRAPH_COLS = 32;

  localparam int NODE_W    = 7;
  localparam int ROW_W     = $clog2(NODES);
  localparam int COL_MAX   = (SEL_COLS > GRAPH_COLS) ? SEL_COLS : GRAPH_COLS;
  localparam int COL_W     = $clog2(COL_MAX + 1);
  localparam int SEL_DEPTH  = NODES * SEL_COLS;
  localparam int EDGE_DEPTH = NODES * GRAPH_COLS;
  localparam int SEL_AW    = (SEL_DEPTH > 1) ? $clog2(SEL_DEPTH) : 1;
  localparam int EDGE_AW   = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
  localparam int DEPTH_MAX = (SEL_DEPTH > EDGE_DEPTH) ? SEL_DEPTH : EDGE_DEPTH;
  localparam int CLR_W     = $clog2(DEPTH_MAX + 1);

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_REM = 1'b1;

  // phases of one item
  localparam logic [1:0] PH_SEL_A  = 2'd0;
  localparam logic [1:0] PH_SCAN_B = 2'd1;
  localparam logic [1:0] PH_EDGE_A = 2'd2;
  localparam logic [1:0] PH_EDGE_B = 2'd3;

  typedef struct packed {
    logic       clr_step;
    logic       capture;
    logic       op_start;
    logic       set_rule;
    logic       cnt_act;
    logic       walk_en;
    logic       fill_en;
    logic       out_load;
    logic [1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_range;
    logic func;
    logic mode;
    logic rule;
    logic walk_done;
    logic need_fill;
    logic fill_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/edge_list_table_update_top.sv
`default_nettype none
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------
// in       | in_valid / in_ready   | func, node_a, other_node
// out      | out_valid / out_ready | graph_changed, row_full
// cfg      | cfg_we                | cfg_wdata (rule_mode)
//
// One item at a time; the single read port of each table walks a row one
// column per cycle (up to four row walks plus zero fills per item).
// After reset a clearing pass of NODES*max(SEL_COLS,GRAPH_COLS) = 2048
// writes runs before the first item is taken; cfg writes are taken always.
// A finished result waits in the output register; the next item is taken.
module edge_list_table_update_top (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire                        cfg_wdata,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        func,
  input  wire [eltu_pkg::NODE_W-1:0] node_a,
  input  wire [eltu_pkg::NODE_W-1:0] other_node,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic                       graph_changed,
  output logic                       row_full
);
  import eltu_pkg::*;

  cmd_t    cmd;
  status_t st;

  eltu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  eltu_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .func          (func),
    .node_a        (node_a),
    .other_node    (other_node),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .graph_changed (graph_changed),
    .row_full      (row_full)
  );

endmodule
`default_nettype wire

// File: rtl/eltu_ctrl.sv
`default_nettype none
module eltu_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  eltu_pkg::status_t st,
  output eltu_pkg::cmd_t    cmd
);
  import eltu_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_OP    = 4'd3;
  localparam logic [3:0] S_CNT   = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_FILL  = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      phase <= PH_SEL_A;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.phase  = phase;
    in_ready   = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        phase_next = PH_SEL_A;
        state_next = st.in_range ? S_OP : S_FIN;
      end
      S_OP: begin
        if (phase == PH_SCAN_B) begin
          if (st.mode) begin
            cmd.set_rule = 1'b1;
            phase_next   = PH_EDGE_A;
          end else begin
            cmd.op_start = 1'b1;
            state_next   = S_WALK;
          end
        end else if (phase != PH_SEL_A && !st.rule) begin
          state_next = S_FIN;
        end else begin
          cmd.op_start = 1'b1;
          state_next   = S_CNT;
        end
      end
      S_CNT: begin
        cmd.cnt_act = 1'b1;
        state_next  = (st.func == FUNC_ADD) ? S_NEXT : S_WALK;
      end
      S_WALK: begin
        cmd.walk_en = 1'b1;
        if (st.walk_done)
          state_next = (phase != PH_SCAN_B && st.need_fill) ? S_FILL : S_NEXT;
      end
      S_FILL: begin
        cmd.fill_en = 1'b1;
        if (st.fill_done) state_next = S_NEXT;
      end
      S_NEXT: begin
        if (phase == PH_EDGE_B) begin
          state_next = S_FIN;
        end else begin
          phase_next = phase + 2'd1;
          state_next = S_OP;
        end
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/eltu_dp.sv
`default_nettype none
module eltu_dp (
  input  wire                          clk,
  input  wire                          rst,
  input  eltu_pkg::cmd_t               cmd,
  output eltu_pkg::status_t            st,
  input  wire                          cfg_we,
  input  wire                          cfg_wdata,
  input  wire                          func,
  input  wire [eltu_pkg::NODE_W-1:0]   node_a,
  input  wire [eltu_pkg::NODE_W-1:0]   other_node,
  input  wire                          out_ready,
  output logic                         out_valid,
  output logic                         graph_changed,
  output logic                         row_full
);
  import eltu_pkg::*;

  logic [NODE_W-1:0] sel_mem  [SEL_DEPTH];
  logic [NODE_W-1:0] edge_mem [EDGE_DEPTH];
  logic [COL_W-1:0]  scnt_mem [NODES];
  logic [COL_W-1:0]  ecnt_mem [NODES];

  logic              mode;
  logic              func_q;
  logic [NODE_W-1:0] a_q, b_q;
  logic              rule, full, hit;
  logic [CLR_W-1:0]  clr;
  logic [COL_W-1:0]  rd_i, proc_i, w, newcnt;
  logic              pend;
  logic [NODE_W-1:0] sel_rd, edge_rd;
  logic [COL_W-1:0]  scnt_rd, ecnt_rd;

  logic              in_range, is_edge, is_scan;
  logic [ROW_W-1:0]  a_idx, b_idx, row;
  logic [NODE_W-1:0] val, rdata;
  logic [COL_W-1:0]  cols, cnt_q, cnt_dec;
  logic              hit_now, walk_done;
  logic              wr_en, cnt_we, clearing;
  logic [COL_W-1:0]  wr_col, cnt_wd;
  logic [NODE_W-1:0] wr_dat;
  logic [SEL_AW-1:0]  sel_waddr, sel_raddr;
  logic [EDGE_AW-1:0] edge_waddr, edge_raddr;

  assign in_range = (a_q != '0) && (int'(a_q) <= NODES) &&
                    (b_q != '0) && (int'(b_q) <= NODES);
  assign a_idx    = ROW_W'(a_q - NODE_W'(1));
  assign b_idx    = ROW_W'(b_q - NODE_W'(1));
  assign is_edge  = cmd.phase[1];
  assign is_scan  = (cmd.phase == PH_SCAN_B);
  assign row      = cmd.phase[0] ? b_idx : a_idx;
  assign val      = cmd.phase[0] ? a_q : b_q;
  assign cols     = is_edge ? COL_W'(GRAPH_COLS) : COL_W'(SEL_COLS);
  assign rdata    = is_edge ? edge_rd : sel_rd;
  assign cnt_q    = is_edge ? ecnt_rd : scnt_rd;
  assign cnt_dec  = (cnt_q == '0) ? '0 : cnt_q - COL_W'(1);
  assign hit_now  = hit || (pend && rdata == val);
  assign walk_done = pend && (proc_i == cols - COL_W'(1));
  assign clearing = cmd.clr_step;

  // one table write per cycle: append, compaction or zero fill
  always_comb begin
    wr_en  = 1'b0;
    wr_col = cnt_q;
    wr_dat = val;
    cnt_we = 1'b0;
    cnt_wd = cnt_dec;
    if (cmd.cnt_act) begin
      cnt_we = 1'b1;
      if (func_q == FUNC_ADD) begin
        cnt_we = (cnt_q < cols);
        wr_en  = (cnt_q < cols);
        cnt_wd = cnt_q + COL_W'(1);
      end
    end else if (cmd.walk_en && pend && !is_scan) begin
      if (newcnt == '0) begin
        wr_en  = (rdata == val);
        wr_col = proc_i;
        wr_dat = '0;
      end else begin
        wr_en  = (rdata != val) && (rdata != '0);
        wr_col = w;
        wr_dat = rdata;
      end
    end else if (cmd.fill_en) begin
      wr_en  = (w < cols);
      wr_col = w;
      wr_dat = '0;
    end
  end

  assign sel_waddr  = clearing ? SEL_AW'(clr) :
                      SEL_AW'(int'(row) * SEL_COLS + int'(wr_col));
  assign edge_waddr = clearing ? EDGE_AW'(clr) :
                      EDGE_AW'(int'(row) * GRAPH_COLS + int'(wr_col));
  assign sel_raddr  = SEL_AW'(int'(row) * SEL_COLS + int'(rd_i));
  assign edge_raddr = EDGE_AW'(int'(row) * GRAPH_COLS + int'(rd_i));

  always_ff @(posedge clk) begin
    if ((clearing && int'(clr) < SEL_DEPTH) || (wr_en && !is_edge))
      sel_mem[sel_waddr] <= clearing ? '0 : wr_dat;
    sel_rd <= sel_mem[sel_raddr];
  end

  always_ff @(posedge clk) begin
    if ((clearing && int'(clr) < EDGE_DEPTH) || (wr_en && is_edge))
      edge_mem[edge_waddr] <= clearing ? '0 : wr_dat;
    edge_rd <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (clearing && int'(clr) < NODES)
      scnt_mem[clr[ROW_W-1:0]] <= '0;
    else if (cnt_we && !is_edge)
      scnt_mem[row] <= cnt_wd;
    scnt_rd <= scnt_mem[row];
  end

  always_ff @(posedge clk) begin
    if (clearing && int'(clr) < NODES)
      ecnt_mem[clr[ROW_W-1:0]] <= '0;
    else if (cnt_we && is_edge)
      ecnt_mem[row] <= cnt_wd;
    ecnt_rd <= ecnt_mem[row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      clr       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) mode <= cfg_wdata;
      if (clearing && int'(clr) < DEPTH_MAX) clr <= clr + CLR_W'(1);
      if (cmd.op_start) pend <= 1'b0;
      else if (cmd.walk_en) pend <= (rd_i < cols);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      a_q    <= node_a;
      b_q    <= other_node;
      rule   <= 1'b0;
      full   <= 1'b0;
    end
    if (cmd.set_rule) rule <= 1'b1;
    if (cmd.op_start) begin
      rd_i <= '0;
      w    <= '0;
      hit  <= 1'b0;
    end
    if (cmd.cnt_act) begin
      newcnt <= cnt_dec;
      if (func_q == FUNC_ADD && cnt_q >= cols) full <= 1'b1;
    end
    if (cmd.walk_en) begin
      if (rd_i < cols) begin
        proc_i <= rd_i;
        rd_i   <= rd_i + COL_W'(1);
      end
      hit <= hit_now;
      if (is_scan && walk_done) rule <= hit_now;
      if (pend && !is_scan && newcnt != '0 && rdata != val && rdata != '0)
        w <= w + COL_W'(1);
    end
    if (cmd.fill_en && w < cols) w <= w + COL_W'(1);
    if (cmd.out_load) begin
      graph_changed <= rule;
      row_full      <= full;
    end
  end

  always_comb begin
    st.clr_done  = (int'(clr) == DEPTH_MAX);
    st.in_range  = in_range;
    st.func      = func_q;
    st.mode      = mode;
    st.rule      = rule;
    st.walk_done = walk_done;
    st.need_fill = (func_q == FUNC_REM) && (newcnt != '0);
    st.fill_done = (w >= cols - COL_W'(1));
    st.out_busy  = out_valid && !out_ready;
  end

endmodule
`default_nettype wire
